/* rtl/tcl_pkg.sv */
// shared types and constants for the tty canonical line discipline
package tcl_pkg;

    // input beat
    typedef struct packed {
        logic       opcode;
        logic [7:0] in_char;
    } t_in;

    // result beat
    typedef struct packed {
        logic [3:0] status;
        logic [7:0] out_char;
        logic       line_end;
        logic [1:0] signal_kind;
        logic [1:0] echo_mode;
        logic [7:0] echo_char;
        logic [7:0] erase_count;
    } t_out;

    // line memory access request
    typedef struct packed {
        logic we;
        logic re;
    } t_mem_ctl;

    // opcodes
    localparam logic OP_RECEIVE = 1'b0;
    localparam logic OP_READ    = 1'b1;

    // status codes
    localparam logic [3:0] ST_IGNORED = 4'd0;
    localparam logic [3:0] ST_STORED  = 4'd1;
    localparam logic [3:0] ST_LINE    = 4'd2;
    localparam logic [3:0] ST_EOF     = 4'd3;
    localparam logic [3:0] ST_SIGNAL  = 4'd4;
    localparam logic [3:0] ST_READ    = 4'd5;
    localparam logic [3:0] ST_NOREAD  = 4'd6;
    localparam logic [3:0] ST_RAW     = 4'd7;
    localparam logic [3:0] ST_BUSY    = 4'd8;

    // signal kinds
    localparam logic [1:0] SIG_NONE = 2'd0;
    localparam logic [1:0] SIG_INTR = 2'd1;
    localparam logic [1:0] SIG_QUIT = 2'd2;
    localparam logic [1:0] SIG_SUSP = 2'd3;

    // echo modes
    localparam logic [1:0] ECHO_NONE  = 2'd0;
    localparam logic [1:0] ECHO_PLAIN = 2'd1;
    localparam logic [1:0] ECHO_CARET = 2'd2;
    localparam logic [1:0] ECHO_ERASE = 2'd3;

    // configuration register indexes
    localparam logic [1:0] REG_MODE   = 2'd0;
    localparam logic [1:0] REG_SIGNAL = 2'd1;
    localparam logic [1:0] REG_EDIT   = 2'd2;

    localparam int CFG_W = 40;

    // mode flag bit positions
    localparam int FB_CANON = 0;
    localparam int FB_SIG   = 1;
    localparam int FB_ECHO  = 2;
    localparam int FB_CARET = 3;
    localparam int FB_CRNL  = 4;
    localparam int FB_NLCR  = 5;
    localparam int FB_IGNCR = 6;

    // register reset values
    localparam logic [6:0]  MODE_RST   = 7'd31;
    localparam logic [23:0] SIGNAL_RST = 24'h1A1C03;
    localparam logic [39:0] EDIT_RST   = 40'hFFFF04157F;

    // characters
    localparam logic [7:0] CH_CR      = 8'd13;
    localparam logic [7:0] CH_NL      = 8'd10;
    localparam logic [7:0] CH_TAB     = 8'd9;
    localparam logic [7:0] CH_AT      = 8'd64;
    localparam logic [7:0] CTRL_LIMIT = 8'd32;

endpackage

/* rtl/tcl_ram.sv */
// generic single-port ram with registered read
module tcl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/tcl_ctrl.sv */
// line state, configuration registers and per-beat key decision
module tcl_ctrl #(
    parameter int LINE_DEPTH    = 256,
    parameter int DISABLED_CODE = 255
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_fire,
    input  tcl_pkg::t_in                  i_item,
    input  logic                          i_cfg_we,
    input  logic [1:0]                    i_cfg_index,
    input  logic [tcl_pkg::CFG_W-1:0]     i_cfg_data,
    output tcl_pkg::t_out                 o_res,
    output logic                          o_res_mem,
    output tcl_pkg::t_mem_ctl             o_mem_ctl,
    output logic [$clog2(LINE_DEPTH)-1:0] o_mem_addr,
    output logic [7:0]                    o_mem_wdata
);
    import tcl_pkg::*;

    localparam int LEN_W = $clog2(LINE_DEPTH);
    localparam logic [7:0] DIS = 8'(DISABLED_CODE);
    localparam logic [LEN_W:0] LEN_LIMIT = (LEN_W+1)'(LINE_DEPTH - 1);

    logic [6:0]       r_mode;
    logic [23:0]      r_sigc;
    logic [39:0]      r_editc;
    logic [LEN_W-1:0] r_len, n_len;
    logic [LEN_W-1:0] r_pos, n_pos;
    logic             r_rdy, n_rdy;

    logic [7:0]       ch;
    logic             drop_cr;
    logic [2:0]       sig_hit;
    logic [4:0]       edit_hit;
    logic [1:0]       echo_mode;
    logic [7:0]       echo_char;
    logic [LEN_W+7:0] kill_cnt;
    logic             echo_on;

    function automatic logic hit(input logic [7:0] code, input logic [7:0] c);
        return (code != DIS) && (code == c);
    endfunction

    always_comb begin
        // translation
        ch      = i_item.in_char;
        drop_cr = 1'b0;
        if (r_mode[FB_CRNL] && i_item.in_char == CH_CR) begin
            ch = CH_NL;
        end else if (r_mode[FB_NLCR] && i_item.in_char == CH_NL) begin
            ch = CH_CR;
        end else if (r_mode[FB_IGNCR] && i_item.in_char == CH_CR) begin
            drop_cr = 1'b1;
        end
        for (int k = 0; k < 3; k++) begin
            sig_hit[k] = hit(r_sigc[8*k +: 8], ch);
        end
        for (int k = 0; k < 5; k++) begin
            edit_hit[k] = hit(r_editc[8*k +: 8], ch);
        end
        // echo of the translated byte
        echo_on   = r_mode[FB_ECHO];
        echo_mode = ECHO_NONE;
        echo_char = 8'd0;
        if (echo_on) begin
            if (ch != CH_NL && r_mode[FB_CARET] && ch != 8'd0 && ch < CTRL_LIMIT
                && ch != CH_TAB) begin
                echo_mode = ECHO_CARET;
                echo_char = ch + CH_AT;
            end else begin
                echo_mode = ECHO_PLAIN;
                echo_char = ch;
            end
        end
        kill_cnt = (LEN_W+8)'(r_len);
    end

    always_comb begin
        o_res       = '0;
        o_res_mem   = 1'b0;
        o_mem_ctl   = '0;
        o_mem_addr  = r_len;
        o_mem_wdata = ch;
        n_len       = r_len;
        n_pos       = r_pos;
        n_rdy       = r_rdy;
        if (i_item.opcode == OP_READ) begin
            if (!r_rdy || r_pos >= r_len) begin
                o_res.status = ST_NOREAD;
                n_rdy = 1'b0;
                n_len = '0;
                n_pos = '0;
            end else begin
                o_res.status = ST_READ;
                o_res_mem    = 1'b1;
                o_mem_ctl.re = 1'b1;
                o_mem_addr   = r_pos;
                n_pos        = r_pos + LEN_W'(1);
                if (r_pos + LEN_W'(1) == r_len) begin
                    o_res.line_end = 1'b1;
                    n_rdy = 1'b0;
                    n_len = '0;
                    n_pos = '0;
                end
            end
        end else if (r_rdy) begin
            o_res.status = ST_BUSY;
        end else if (drop_cr) begin
            o_res.status = ST_IGNORED;
        end else if (r_mode[FB_SIG] && sig_hit != 3'b000) begin
            o_res.status = ST_SIGNAL;
            priority if (sig_hit[0]) o_res.signal_kind = SIG_INTR;
            else if (sig_hit[1])     o_res.signal_kind = SIG_QUIT;
            else                     o_res.signal_kind = SIG_SUSP;
            n_len = '0;
            n_pos = '0;
        end else if (!r_mode[FB_CANON]) begin
            o_res.status    = ST_RAW;
            o_res.out_char  = ch;
            o_res.echo_mode = echo_mode;
            o_res.echo_char = echo_char;
        end else if (edit_hit[0]) begin
            // erase one byte
            o_res.status = ST_STORED;
            if (r_len != '0) begin
                n_len = r_len - LEN_W'(1);
                if (echo_on) begin
                    o_res.echo_mode   = ECHO_ERASE;
                    o_res.erase_count = 8'd1;
                end
            end
        end else if (edit_hit[1]) begin
            // kill the whole line
            o_res.status = ST_STORED;
            if (echo_on && r_len != '0) begin
                o_res.echo_mode   = ECHO_ERASE;
                o_res.erase_count = (kill_cnt > (LEN_W+8)'(255)) ? 8'd255 : kill_cnt[7:0];
            end
            n_len = '0;
        end else if (edit_hit[2]) begin
            if (r_len == '0) begin
                o_res.status = ST_EOF;
            end else begin
                o_res.status = ST_LINE;
                n_rdy = 1'b1;
                n_pos = '0;
            end
        end else begin
            o_res.status = ST_IGNORED;
            if ({1'b0, r_len} < LEN_LIMIT) begin
                o_mem_ctl.we    = 1'b1;
                n_len           = r_len + LEN_W'(1);
                o_res.status    = ST_STORED;
                o_res.echo_mode = echo_mode;
                o_res.echo_char = echo_char;
            end
            if (ch == CH_NL || edit_hit[3] || edit_hit[4]) begin
                o_res.status = ST_LINE;
                n_rdy = 1'b1;
                n_pos = '0;
            end
        end
        if (!i_fire) begin
            o_mem_ctl = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_RST;
            r_sigc  <= SIGNAL_RST;
            r_editc <= EDIT_RST;
            r_len   <= '0;
            r_pos   <= '0;
            r_rdy   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_MODE:   r_mode  <= i_cfg_data[6:0];
                    REG_SIGNAL: r_sigc  <= i_cfg_data[23:0];
                    REG_EDIT:   r_editc <= i_cfg_data[39:0];
                    default:    ;
                endcase
            end
            if (i_fire) begin
                r_len <= n_len;
                r_pos <= n_pos;
                r_rdy <= n_rdy;
            end
        end
    end

    // one port: a beat never both writes and reads the line memory
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_mem_ctl.we && o_mem_ctl.re))
        else $error("line memory read and write in one cycle");

    // a waiting line is never empty and the read position stays inside it
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rdy |-> (r_len != '0) && (r_pos < r_len))
        else $error("read position outside the waiting line");

    // read position rests at zero while no line waits
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_rdy |-> (r_pos == '0))
        else $error("read position nonzero with no line waiting");

endmodule

/* rtl/tty_canonical_line_discipline.sv */
// top level of the tty canonical line discipline
// Terminal input line discipline. Each input beat is either a received key
// (opcode 0) or a read of one byte of the completed line (opcode 1), and
// each gives exactly one result beat. The block takes one beat per clock
// unless the output stalls. An accepted beat is decided, with its line-memory
// access, into the decision stage register, then passes with the registered
// read data of the single-port line memory into an output register. Line
// length, read position and the line-ready flag are flip-flops updated as
// each beat is taken; the line bytes live in the memory, so keys are written
// and read bytes fetched through its one port, at most one access per beat.
// Configuration is a plain write port (index 0 mode flags, 1 signal chars,
// 2 edit chars), to be used only while the block is idle.
module tty_canonical_line_discipline #(
    parameter int LINE_DEPTH    = 256,
    parameter int DISABLED_CODE = 255
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // input channel
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  tcl_pkg::t_in              i_in_data,
    // result channel
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output tcl_pkg::t_out             o_out_data,
    // configuration write port
    input  logic                      i_cfg_we,
    input  logic [1:0]                i_cfg_index,
    input  logic [tcl_pkg::CFG_W-1:0] i_cfg_data
);
    import tcl_pkg::*;

    localparam int LEN_W = $clog2(LINE_DEPTH);

    logic             fire;
    logic             s1_adv;
    t_out             res;
    logic             res_mem;
    t_mem_ctl         mem_ctl;
    logic [LEN_W-1:0] mem_addr;
    logic [7:0]       mem_wdata;
    logic [7:0]       mem_rdata;
    t_out             s1_out;

    // decision stage register: result waiting for the memory read data
    logic             r_s1_valid;
    t_out             r_s1_res;
    logic             r_s1_mem;
    // output register
    logic             r_out_valid;
    t_out             r_out_data;

    // the decision stage moves on whenever the output register is free
    assign s1_adv     = !r_out_valid || i_out_ready;
    assign o_in_ready = !r_s1_valid || s1_adv;
    assign fire       = i_in_valid && o_in_ready;

    tcl_ctrl #(
        .LINE_DEPTH    (LINE_DEPTH),
        .DISABLED_CODE (DISABLED_CODE)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_item      (i_in_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_res       (res),
        .o_res_mem   (res_mem),
        .o_mem_ctl   (mem_ctl),
        .o_mem_addr  (mem_addr),
        .o_mem_wdata (mem_wdata)
    );

    // line memory; its read data stays put until the next read, and a read
    // is only issued when the previous beat leaves the decision stage
    tcl_ram #(
        .WIDTH (8),
        .DEPTH (LINE_DEPTH)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (mem_ctl.we),
        .i_re    (mem_ctl.re),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    // read data beat takes the byte from the line memory
    always_comb begin
        s1_out = r_s1_res;
        if (r_s1_mem) begin
            s1_out.out_char = mem_rdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_s1_valid <= fire;
            end
            if (s1_adv) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_s1_res <= res;
            r_s1_mem <= res_mem;
        end
        if (s1_adv && r_s1_valid) begin
            r_out_data <= s1_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // a beat held in the decision stage stays until the output frees up
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !s1_adv |=> r_s1_valid)
        else $error("decision stage beat lost while stalled");

    // only a read data beat takes its byte from the memory
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && r_s1_mem |-> r_s1_res.status == ST_READ)
        else $error("memory byte attached to a non-read beat");

    // input is refused only when both stages are full and output stalls
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> r_s1_valid && r_out_valid && !i_out_ready)
        else $error("input refused with room in the pipeline");

    // memory is touched only on an accepted beat
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mem_ctl.we || mem_ctl.re) |-> fire)
        else $error("line memory access without an accepted beat");

endmodule

/* tb/line_discipline_checker.sv */
// result checker for the tty canonical line discipline: predicts and compares every beat
`timescale 1ns / 1ps
module line_discipline_checker #(
    parameter int         LINE_DEPTH = 256,
    parameter logic [7:0] DISABLED   = 8'hFF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    input  logic                      i_in_ready,
    input  tcl_pkg::t_in              i_in_data,
    input  logic                      i_out_valid,
    input  logic                      i_out_ready,
    input  tcl_pkg::t_out             i_out_data,
    input  logic                      i_cfg_we,
    input  logic [1:0]                i_cfg_index,
    input  logic [tcl_pkg::CFG_W-1:0] i_cfg_data,
    output int                        o_fail_count,
    output int                        o_pending,
    output int                        o_results
);
    import tcl_pkg::*;

    // character slots of the edit register
    localparam int SLOT_ERASE = 0;
    localparam int SLOT_KILL  = 1;
    localparam int SLOT_EOF   = 2;
    localparam int SLOT_EOL   = 3;
    localparam int SLOT_EOL2  = 4;

    logic [6:0]  mode_q;
    logic [23:0] sig_q;
    logic [39:0] edit_q;
    logic [7:0]  line_mem [LINE_DEPTH];
    int          line_len;
    int          rd_pos;
    bit          line_done;
    t_out        expected_results [$];

    function automatic bit is_code(logic [7:0] code, logic [7:0] ch);
        return code != DISABLED && code == ch;
    endfunction

    function automatic logic [7:0] edit_code(int slot);
        return edit_q[8*slot +: 8];
    endfunction

    function automatic t_out with_echo(t_out r, logic [7:0] ch);
        if (!mode_q[FB_ECHO]) return r;
        if (ch != CH_NL && mode_q[FB_CARET] && ch > 0 && ch < CTRL_LIMIT && ch != CH_TAB) begin
            r.echo_mode = ECHO_CARET;
            r.echo_char = ch + CH_AT;
        end else begin
            r.echo_mode = ECHO_PLAIN;
            r.echo_char = ch;
        end
        return r;
    endfunction

    function automatic t_out with_erase(t_out r, int count);
        if (mode_q[FB_ECHO] && count > 0) begin
            r.echo_mode   = ECHO_ERASE;
            r.erase_count = (count > 255) ? 8'd255 : 8'(count);
        end
        return r;
    endfunction

    function automatic void clear_line();
        line_done = 1'b0;
        line_len  = 0;
        rd_pos    = 0;
    endfunction

    function automatic t_out take_key(logic [7:0] key);
        t_out       r;
        logic [7:0] ch;
        logic [1:0] kind;
        r    = '0;
        ch   = key;
        kind = SIG_NONE;
        if (line_done) begin
            r.status = ST_BUSY;
            return r;
        end
        if (mode_q[FB_CRNL] && ch == CH_CR) begin
            ch = CH_NL;
        end else if (mode_q[FB_NLCR] && ch == CH_NL) begin
            ch = CH_CR;
        end else if (mode_q[FB_IGNCR] && ch == CH_CR) begin
            r.status = ST_IGNORED;
            return r;
        end
        if (mode_q[FB_SIG]) begin
            if (is_code(sig_q[7:0], ch)) kind = SIG_INTR;
            else if (is_code(sig_q[15:8], ch)) kind = SIG_QUIT;
            else if (is_code(sig_q[23:16], ch)) kind = SIG_SUSP;
        end
        if (kind != SIG_NONE) begin
            r.status      = ST_SIGNAL;
            r.signal_kind = kind;
            line_len      = 0;
            rd_pos        = 0;
            return r;
        end
        if (!mode_q[FB_CANON]) begin
            r.status   = ST_RAW;
            r.out_char = ch;
            return with_echo(r, ch);
        end
        if (is_code(edit_code(SLOT_ERASE), ch)) begin
            r.status = ST_STORED;
            if (line_len > 0) begin
                line_len--;
                r = with_erase(r, 1);
            end
            return r;
        end
        if (is_code(edit_code(SLOT_KILL), ch)) begin
            r.status = ST_STORED;
            r        = with_erase(r, line_len);
            line_len = 0;
            return r;
        end
        if (is_code(edit_code(SLOT_EOF), ch)) begin
            if (line_len == 0) begin
                r.status = ST_EOF;
            end else begin
                r.status  = ST_LINE;
                line_done = 1'b1;
                rd_pos    = 0;
            end
            return r;
        end
        r.status = ST_IGNORED;
        if (line_len + 1 < LINE_DEPTH) begin
            line_mem[line_len] = ch;
            line_len++;
            r.status = ST_STORED;
            r        = with_echo(r, ch);
        end
        if (ch == CH_NL || is_code(edit_code(SLOT_EOL), ch)
            || is_code(edit_code(SLOT_EOL2), ch)) begin
            r.status  = ST_LINE;
            line_done = 1'b1;
            rd_pos    = 0;
        end
        return r;
    endfunction

    function automatic t_out take_read();
        t_out r;
        r = '0;
        if (!line_done || rd_pos >= line_len) begin
            clear_line();
            r.status = ST_NOREAD;
            return r;
        end
        r.status   = ST_READ;
        r.out_char = line_mem[rd_pos];
        rd_pos++;
        if (rd_pos >= line_len) begin
            r.line_end = 1'b1;
            clear_line();
        end
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        if (o_fail_count < 40) $display("[%0t] mismatch: %s", $realtime, msg);
        o_fail_count++;
    endtask

    task automatic compare_result(t_out got, t_out want);
        if (got.status != want.status)
            report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
        if (got.out_char != want.out_char)
            report_mismatch($sformatf("out_char %0h, want %0h", got.out_char, want.out_char));
        if (got.line_end != want.line_end)
            report_mismatch($sformatf("line_end %0d, want %0d", got.line_end, want.line_end));
        if (got.signal_kind != want.signal_kind)
            report_mismatch($sformatf("signal_kind %0d, want %0d",
                                      got.signal_kind, want.signal_kind));
        if (got.echo_mode != want.echo_mode)
            report_mismatch($sformatf("echo_mode %0d, want %0d", got.echo_mode, want.echo_mode));
        if (got.echo_char != want.echo_char)
            report_mismatch($sformatf("echo_char %0h, want %0h", got.echo_char, want.echo_char));
        if (got.erase_count != want.erase_count)
            report_mismatch($sformatf("erase_count %0d, want %0d",
                                      got.erase_count, want.erase_count));
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            mode_q = MODE_RST;
            sig_q  = SIGNAL_RST;
            edit_q = EDIT_RST;
            clear_line();
            expected_results.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_MODE:   mode_q = i_cfg_data[6:0];
                    REG_SIGNAL: sig_q  = i_cfg_data[23:0];
                    REG_EDIT:   edit_q = i_cfg_data[39:0];
                    default: ;
                endcase
            end
            // a result can never belong to a beat taken at the same edge
            if (i_out_valid && i_out_ready) begin
                o_results++;
                if (expected_results.size() == 0)
                    report_mismatch($sformatf("result with nothing pending, status %0d",
                                              i_out_data.status));
                else
                    compare_result(i_out_data, expected_results.pop_front());
            end
            if (i_in_valid && i_in_ready) begin
                if (i_in_data.opcode == OP_READ)
                    expected_results.push_back(take_read());
                else
                    expected_results.push_back(take_key(i_in_data.in_char));
            end
        end
        o_pending = expected_results.size();
    end

endmodule

/* tb/tb_tty_canonical_line_discipline.sv */
// testbench top for the tty canonical line discipline: stimulus, flow control and verdict
`timescale 1ns / 1ps
module tb_tty_canonical_line_discipline;
    import tcl_pkg::*;

    localparam int DEPTH       = 256;
    localparam int HOLD_CYCLES = 300;   // receiver hold-off that backs the block up
    localparam int PHASE_BEATS = 110;   // random beats per register setting

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             i_in_valid;
    logic             o_in_ready;
    t_in              i_in_data;
    logic             o_out_valid;
    logic             i_out_ready;
    t_out             o_out_data;
    logic             i_cfg_we;
    logic [1:0]       i_cfg_index;
    logic [CFG_W-1:0] i_cfg_data;

    int fail_count;
    int pending;
    int results;

    // flow control knobs shared with the receiver process
    bit calm;       // no idling on either side while set
    bit hold_req;   // receiver holds off for HOLD_CYCLES, then clears it

    int beats_sent;
    int settings_applied;

    // stimulus-side copy of the registers, used only to aim the key mix
    logic [6:0]  cur_mode;
    logic [23:0] cur_sig;
    logic [39:0] cur_edit;

    wire [7:0] intr_ch  = cur_sig[7:0];
    wire [7:0] quit_ch  = cur_sig[15:8];
    wire [7:0] susp_ch  = cur_sig[23:16];
    wire [7:0] erase_ch = cur_edit[7:0];
    wire [7:0] kill_ch  = cur_edit[15:8];
    wire [7:0] eof_ch   = cur_edit[23:16];
    wire [7:0] eol_ch   = cur_edit[31:24];
    wire [7:0] eol2_ch  = cur_edit[39:32];

    // 2 ns clock
    always #1 i_clk = ~i_clk;

    tty_canonical_line_discipline #(
        .LINE_DEPTH    (DEPTH),
        .DISABLED_CODE (255)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    line_discipline_checker #(
        .LINE_DEPTH (DEPTH),
        .DISABLED   (8'hFF)
    ) u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_in_data    (i_in_data),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_out_data   (o_out_data),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_results    (results)
    );

    // offer one beat, with a random gap in front of it, and hold it until taken
    task automatic send_beat(logic op, logic [7:0] ch);
        t_in beat;
        beat.opcode  = op;
        beat.in_char = ch;
        if (!calm) begin
            while ($urandom_range(99) < 19) begin
                i_in_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_in_valid <= 1'b1;
        i_in_data  <= beat;
        do @(posedge i_clk); while (!o_in_ready);
        beats_sent++;
    endtask

    task automatic send_key(logic [7:0] ch);
        send_beat(OP_RECEIVE, ch);
    endtask

    // in_char is a don't-care on reads, so it carries noise
    task automatic send_read();
        send_beat(OP_READ, 8'($urandom_range(255)));
    endtask

    // wait until all results are in, then let the two-stage pipe settle
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        repeat (4) @(posedge i_clk);
    endtask

    // rewrite all three registers on consecutive cycles while the block is idle
    task automatic apply_config(logic [6:0] mode, logic [23:0] sig, logic [39:0] edit);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= REG_MODE;
        i_cfg_data  <= CFG_W'(mode);
        @(posedge i_clk);
        i_cfg_index <= REG_SIGNAL;
        i_cfg_data  <= CFG_W'(sig);
        @(posedge i_clk);
        i_cfg_index <= REG_EDIT;
        i_cfg_data  <= CFG_W'(edit);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cur_mode = mode;
        cur_sig  = sig;
        cur_edit = edit;
        settings_applied++;
    endtask

    // mostly control codes, sometimes disabled, sometimes anything
    function automatic logic [7:0] rand_code();
        int roll;
        roll = $urandom_range(5);
        if (roll == 0) return 8'hFF;
        if (roll < 4) return 8'($urandom_range(31));
        return 8'($urandom_range(255));
    endfunction

    // line content: mostly printable text with a sprinkle of editing and controls
    function automatic logic [7:0] pick_char();
        int roll;
        roll = $urandom_range(99);
        if (roll < 74) return 8'($urandom_range(126, 32));
        if (roll < 82) return 8'($urandom_range(255));
        if (roll < 88) return erase_ch;
        if (roll < 90) return kill_ch;
        if (roll < 92) return CH_CR;
        if (roll < 94) return CH_TAB;
        if (roll < 96) return 8'($urandom_range(31, 1));
        if (roll < 98) return cur_sig[8*$urandom_range(2) +: 8];
        if (roll < 99) return eol_ch;
        return eol2_ch;
    endfunction

    function automatic logic [7:0] pick_term();
        case ($urandom_range(5))
            0:       return CH_CR;
            1:       return eof_ch;
            2:       return eol_ch;
            3:       return eol2_ch;
            default: return CH_NL;
        endcase
    endfunction

    // typed lines followed by a read-out, with bursts of raw noise between them
    task automatic run_lines(int count);
        int stop_at;
        int len;
        stop_at = beats_sent + count;
        while (beats_sent < stop_at) begin
            if ($urandom_range(99) < 82) begin
                len = ($urandom_range(9) == 0) ? $urandom_range(60, 20) : $urandom_range(12, 1);
                repeat (len) send_key(pick_char());
                send_key(pick_term());
                // surplus reads probe the empty line, short ones leave it busy
                repeat (len + $urandom_range(2)) send_read();
            end else begin
                repeat ($urandom_range(5, 1))
                    send_beat(1'($urandom_range(1)), 8'($urandom_range(255)));
            end
        end
    endtask

    // receiver: random stalls, or one long hold-off when asked
    initial begin
        i_out_ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_req) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else begin
                i_out_ready <= calm || ($urandom_range(99) >= 19);
                @(posedge i_clk);
            end
        end
    end

    // run limit, far beyond the slowest legal run
    initial begin
        #1_000_000;
        $display("timeout with %0d results outstanding", pending);
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        logic [6:0]  mode;
        logic [23:0] sig;
        logic [39:0] edit;

        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_data   <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= REG_MODE;
        i_cfg_data  <= '0;
        cur_mode = MODE_RST;
        cur_sig  = SIGNAL_RST;
        cur_edit = EDIT_RST;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed pass on reset settings: canonical, signals, echo, caret, cr to nl
        send_read();            // nothing to read yet
        send_key(eof_ch);       // eof on an empty line
        send_key(erase_ch);     // erase with nothing to remove
        send_key(kill_ch);      // kill with nothing to remove
        send_key("a");
        send_key(8'h01);        // control echoes in caret form
        send_key(CH_TAB);       // tab stays plain
        send_key(8'h00);        // nul stays plain
        send_key(8'hFF);        // disabled code is just a byte
        send_key(erase_ch);     // removes one byte
        send_key(kill_ch);      // removes the rest
        send_key("x");
        send_key(intr_ch);      // interrupt drops the partial line
        send_key(quit_ch);
        send_key(susp_ch);
        send_key("h");
        send_key("i");
        send_key(CH_CR);        // becomes newline and completes the line
        send_key("z");          // refused while the line waits
        repeat (3) send_read(); // last one is marked
        send_read();            // line already gone
        send_key("k");
        send_key(eof_ch);       // eof ends a non-empty line unstored
        send_read();
        send_read();

        // fill the line past capacity: overflow bytes are dropped, newline still ends it
        send_key(kill_ch);
        for (int i = 0; i < DEPTH + 2; i++) send_key(8'("a" + i % 26));
        send_key(CH_NL);
        repeat (DEPTH + 1) send_read();

        // kill of a full line gives the largest erase count
        for (int i = 0; i < DEPTH; i++) send_key(8'("A" + i % 26));
        send_key(kill_ch);
        repeat (2) send_read();

        // random lines over a spread of register settings, extremes included
        for (int p = 0; p < 8; p++) begin
            case (p)
                0: begin    // every flag set
                    mode = 7'h7F; sig = SIGNAL_RST; edit = 40'h3B2E041508;
                end
                1: begin    // raw, no echo, every code disabled
                    mode = 7'h00; sig = 24'hFFFFFF; edit = 40'hFFFFFFFFFF;
                end
                2: begin    // all codes zero
                    mode = 7'h07; sig = 24'h000000; edit = 40'h0000000000;
                end
                3: begin    // ignore cr
                    mode = 7'h41;
                    sig  = {rand_code(), rand_code(), rand_code()};
                    edit = {rand_code(), rand_code(), rand_code(), rand_code(), rand_code()};
                end
                4: begin    // nl to cr, plain echo only
                    mode = 7'h25; sig = SIGNAL_RST; edit = EDIT_RST;
                end
                5: begin
                    mode = 7'h4F;
                    sig  = {rand_code(), rand_code(), rand_code()};
                    edit = {8'h2E, 8'h0D, rand_code(), rand_code(), rand_code()};
                end
                6: begin    // raw with signals and translation
                    mode = 7'h1E; sig = SIGNAL_RST; edit = EDIT_RST;
                end
                default: begin
                    mode = 7'($urandom_range(127));
                    sig  = {rand_code(), rand_code(), rand_code()};
                    edit = {rand_code(), rand_code(), rand_code(), rand_code(), rand_code()};
                end
            endcase
            apply_config(mode, sig, edit);
            calm = (p == 4);
            // long receiver stall while keys keep coming
            if (p == 0) hold_req = 1'b1;
            run_lines(PHASE_BEATS);
        end
        calm = 1'b0;

        wait_idle();
        $display("covered %0d beats under %0d register settings, %0d results compared",
                 beats_sent, settings_applied + 1, results);
        $display("including line overflow, full-line kill and a %0d-cycle receiver stall",
                 HOLD_CYCLES);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
